// ===== hdl/krs_pkg.sv =====
// ----------------------------------------------------------------------------
// krs_pkg: shared types and constants for the keyed ring store
// Sizes, operation and status codes, and the structs passed between blocks.
// ----------------------------------------------------------------------------
package krs_pkg;

  localparam int DEPTH  = 16;
  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_PEEK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  // write to the key and value arrays (same slot)
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } slot_wr_t;

  // write to one of the link arrays
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] link;
  } link_wr_t;

  // slot allocation update
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } alloc_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  occ;
  } result_t;

endpackage

// ===== hdl/krs_ram.sv =====
// ----------------------------------------------------------------------------
// krs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/krs_alloc.sv =====
// ----------------------------------------------------------------------------
// krs_alloc: slot occupancy tracking
// Holds one used bit per slot and offers the lowest-numbered free slot.
// ----------------------------------------------------------------------------
module krs_alloc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  krs_pkg::alloc_cmd_t            cmd,
  output logic [krs_pkg::IDX_W-1:0]      free_idx
);

  logic [krs_pkg::DEPTH-1:0] used_r;
  logic [krs_pkg::DEPTH-1:0] used_nxt;

  always_comb begin
    used_nxt = used_r;
    if (cmd.set) begin
      used_nxt[cmd.idx] = 1'b1;
    end
    if (cmd.clr) begin
      used_nxt[cmd.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // priority encode, lowest free slot wins
  always_comb begin
    free_idx = '0;
    for (int i = krs_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = krs_pkg::IDX_W'(i);
      end
    end
  end

  a_set_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set |-> !used_r[cmd.idx])
    else $error("insert allocated a slot already in use");

  a_clr_used: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> used_r[cmd.idx])
    else $error("remove freed a slot that was not in use");

endmodule

// ===== hdl/krs_ctrl.sv =====
// ----------------------------------------------------------------------------
// krs_ctrl: sequencer for the keyed ring store
// Walks the ring one entry per cycle through a shared key comparator,
// issues link and slot writes, and holds the result register.
// ----------------------------------------------------------------------------
module krs_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  // request
  input  logic                            in_valid,
  output logic                            in_ready,
  input  krs_pkg::action_t                in_action,
  input  logic [krs_pkg::KEY_W-1:0]       in_key,
  input  logic [krs_pkg::DATA_W-1:0]      in_value,
  // result
  output logic                            out_valid,
  input  logic                            out_ready,
  output krs_pkg::result_t                out_res,
  // shared read port of the slot arrays
  output logic                            rd_en,
  output logic [krs_pkg::IDX_W-1:0]       rd_addr,
  input  logic [krs_pkg::KEY_W-1:0]       rd_key,
  input  logic [krs_pkg::DATA_W-1:0]      rd_value,
  input  logic [krs_pkg::IDX_W-1:0]       rd_next,
  input  logic [krs_pkg::IDX_W-1:0]       rd_prev,
  // writes
  output krs_pkg::slot_wr_t               slot_wr,
  output krs_pkg::link_wr_t               next_wr,
  output krs_pkg::link_wr_t               prev_wr,
  // allocation
  output krs_pkg::alloc_cmd_t             alloc_cmd,
  input  logic [krs_pkg::IDX_W-1:0]       free_idx
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INS1  = 6'b000010,
    S_INS2  = 6'b000100,
    S_WALK  = 6'b001000,
    S_SHORT = 6'b010000,
    S_HOLD  = 6'b100000
  } state_t;

  state_t                      state_r, state_nxt;
  krs_pkg::action_t            act_r, act_nxt;
  logic [krs_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [krs_pkg::DATA_W-1:0]  val_r, val_nxt;
  logic [krs_pkg::IDX_W-1:0]   cursor_r, cursor_nxt;
  logic [krs_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [krs_pkg::IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [krs_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic [krs_pkg::IDX_W-1:0]   before_r, before_nxt;
  krs_pkg::result_t            hold_r, hold_nxt;
  krs_pkg::result_t            out_res_r, out_res_nxt;
  logic                        out_valid_r, out_valid_nxt;

  krs_pkg::result_t            res;
  logic                        done;
  logic                        ins_done;
  logic                        out_free;
  logic                        key_hit;

  assign out_free = !out_valid_r || out_ready;
  assign key_hit  = (rd_key == key_r);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    cursor_nxt    = cursor_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    n_nxt         = n_r;
    before_nxt    = before_r;
    hold_nxt      = hold_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = cursor_r;
    slot_wr       = '0;
    next_wr       = '0;
    prev_wr       = '0;
    alloc_cmd     = '0;
    res           = '0;
    res.status    = krs_pkg::STAT_MISS;
    done          = 1'b0;
    ins_done      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_en    = 1'b1;          // prefetch the cursor entry
        if (in_valid) begin
          act_nxt = in_action;
          key_nxt = in_key;
          val_nxt = in_value;
          ptr_nxt = cursor_r;
          n_nxt   = '0;
          priority if (in_action == krs_pkg::ACT_INSERT &&
                       cnt_r < krs_pkg::CNT_W'(krs_pkg::DEPTH)) begin
            state_nxt = S_INS1;
          end else if ((in_action == krs_pkg::ACT_REMOVE ||
                        in_action == krs_pkg::ACT_LOOKUP) && cnt_r != '0) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_SHORT;
          end
        end
      end

      S_INS1: begin
        slot_wr.we    = 1'b1;
        slot_wr.idx   = free_idx;
        slot_wr.key   = key_r;
        slot_wr.value = val_r;
        next_wr.we    = 1'b1;
        next_wr.addr  = free_idx;
        prev_wr.we    = 1'b1;
        prev_wr.addr  = free_idx;
        before_nxt    = rd_prev;
        if (cnt_r == '0) begin
          // first entry links to itself
          next_wr.link = free_idx;
          prev_wr.link = free_idx;
          ins_done     = 1'b1;
        end else begin
          next_wr.link = cursor_r;
          prev_wr.link = rd_prev;
          state_nxt    = S_INS2;
        end
      end

      S_INS2: begin
        next_wr.we   = 1'b1;
        next_wr.addr = before_r;
        next_wr.link = free_idx;
        prev_wr.we   = 1'b1;
        prev_wr.addr = cursor_r;
        prev_wr.link = free_idx;
        ins_done     = 1'b1;
      end

      S_WALK: begin
        if (key_hit) begin
          done       = 1'b1;
          res.status = krs_pkg::STAT_OK;
          res.data   = rd_value;
          if (act_r == krs_pkg::ACT_REMOVE) begin
            alloc_cmd.clr = 1'b1;
            alloc_cmd.idx = ptr_r;
            cnt_nxt       = krs_pkg::CNT_W'(cnt_r - 1'b1);
            if (cnt_r == krs_pkg::CNT_W'(1)) begin
              cursor_nxt = '0;
            end else begin
              next_wr.we   = 1'b1;
              next_wr.addr = rd_prev;
              next_wr.link = rd_next;
              prev_wr.we   = 1'b1;
              prev_wr.addr = rd_next;
              prev_wr.link = rd_prev;
              cursor_nxt   = rd_next;
            end
          end else begin
            cursor_nxt = ptr_r;
          end
        end else if (krs_pkg::CNT_W'(n_r + 1'b1) >= cnt_r) begin
          done = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_next;
          ptr_nxt = rd_next;
          n_nxt   = krs_pkg::CNT_W'(n_r + 1'b1);
        end
      end

      S_SHORT: begin
        done = 1'b1;
        priority if (act_r == krs_pkg::ACT_INSERT) begin
          res.status = krs_pkg::STAT_FULL;
        end else if (act_r == krs_pkg::ACT_PEEK && cnt_r != '0) begin
          res.status = krs_pkg::STAT_OK;
          res.data   = rd_value;
        end else begin
          res.status = krs_pkg::STAT_MISS;
        end
      end

      S_HOLD: begin
        if (out_free) begin
          out_res_nxt   = hold_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ins_done) begin
      done          = 1'b1;
      res.status    = krs_pkg::STAT_OK;
      alloc_cmd.set = 1'b1;
      alloc_cmd.idx = free_idx;
      cursor_nxt    = free_idx;
      cnt_nxt       = krs_pkg::CNT_W'(cnt_r + 1'b1);
    end

    res.occ = cnt_nxt;

    if (done) begin
      if (out_free) begin
        out_res_nxt   = res;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end else begin
        hold_nxt  = res;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    ptr_r     <= ptr_nxt;
    n_r       <= n_nxt;
    before_r  <= before_nxt;
    hold_r    <= hold_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= krs_pkg::CNT_W'(krs_pkg::DEPTH))
    else $error("entry count above capacity");

  a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> cursor_r == '0)
    else $error("cursor not parked at zero on an empty ring");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> n_r < cnt_r)
    else $error("ring walk ran past the entry count");

  a_cnt_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != cnt_nxt |-> done)
    else $error("entry count changed outside a finished transfer");

endmodule

// ===== hdl/keyed_ring_store.sv =====
// ----------------------------------------------------------------------------
// keyed_ring_store: keyed store kept as a circular doubly linked ring
// Top level: stream ports, slot and link memories, allocator, sequencer.
// ----------------------------------------------------------------------------
// One request is in flight at a time: in_tready is high only while the
// sequencer is idle, and one result follows each request. Once taken, a
// peek, a full insert or a request to an empty store ends in one short
// step; an insert takes one write step into an empty ring, two otherwise;
// remove and lookup visit ring entries (1 to DEPTH) as the
// walk follows the next links through the registered read port of the
// slot memories and tests one key per cycle. The result sits in an output
// register, so the next request is taken while it waits for out_tready.
module keyed_ring_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] key, [47:16] value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] data, [36:32] occupancy, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic                          rd_en;
  logic [krs_pkg::IDX_W-1:0]     rd_addr;
  logic [krs_pkg::KEY_W-1:0]     rd_key;
  logic [krs_pkg::DATA_W-1:0]    rd_value;
  logic [krs_pkg::IDX_W-1:0]     rd_next;
  logic [krs_pkg::IDX_W-1:0]     rd_prev;
  krs_pkg::slot_wr_t             slot_wr;
  krs_pkg::link_wr_t             next_wr;
  krs_pkg::link_wr_t             prev_wr;
  krs_pkg::alloc_cmd_t           alloc_cmd;
  logic [krs_pkg::IDX_W-1:0]     free_idx;
  krs_pkg::result_t              out_res;

  krs_ram #(.WIDTH(krs_pkg::KEY_W), .DEPTH(krs_pkg::DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (slot_wr.we),
    .waddr (slot_wr.idx),
    .wdata (slot_wr.key),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_key)
  );

  krs_ram #(.WIDTH(krs_pkg::DATA_W), .DEPTH(krs_pkg::DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (slot_wr.we),
    .waddr (slot_wr.idx),
    .wdata (slot_wr.value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_value)
  );

  krs_ram #(.WIDTH(krs_pkg::IDX_W), .DEPTH(krs_pkg::DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (next_wr.we),
    .waddr (next_wr.addr),
    .wdata (next_wr.link),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_next)
  );

  krs_ram #(.WIDTH(krs_pkg::IDX_W), .DEPTH(krs_pkg::DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prev_wr.we),
    .waddr (prev_wr.addr),
    .wdata (prev_wr.link),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_prev)
  );

  krs_alloc u_alloc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (alloc_cmd),
    .free_idx (free_idx)
  );

  krs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (krs_pkg::action_t'(in_tuser)),
    .in_key    (in_tdata[15:0]),
    .in_value  (in_tdata[47:16]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .rd_next   (rd_next),
    .rd_prev   (rd_prev),
    .slot_wr   (slot_wr),
    .next_wr   (next_wr),
    .prev_wr   (prev_wr),
    .alloc_cmd (alloc_cmd),
    .free_idx  (free_idx)
  );

  assign out_tdata = {3'b000, out_res.occ, out_res.data};
  assign out_tuser = out_res.status;

endmodule
